[hdl/interpolation_search_bound_core_macros.svh]
// assertion macros for the interpolation search bound core
// used by the top level, expects i_clk and i_rst_n in scope
`ifndef INTERPOLATION_SEARCH_BOUND_CORE_MACROS_SVH
`define INTERPOLATION_SEARCH_BOUND_CORE_MACROS_SVH

// property checked on every clock edge out of reset
`define ISB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// implication checked on every clock edge out of reset
`define ISB_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[hdl/isb_pkg.sv]
// package for the interpolation search bound core
// table sizes, widths and beat layout; no dependencies
`default_nettype none
package isb_pkg;
    localparam int KEY_BITS    = 64;
    localparam int TABLE_DEPTH = 4096;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int POS_W       = $clog2(TABLE_DEPTH + 1);
    localparam int CNT_W       = $clog2(POS_W + 1);

    // input tdata layout
    localparam int IN_IDX_LO   = 0;
    localparam int IN_DATA_LO  = IN_IDX_LO + 12;
    localparam int IN_KEY_LO   = IN_DATA_LO + 64;
    localparam int IN_FIRST_LO = IN_KEY_LO + 64;
    localparam int IN_PAST_LO  = IN_FIRST_LO + 13;
    localparam int IN_BITS     = IN_PAST_LO + 13;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((13 + 7) / 8) * 8;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_SEARCH = 1'b1;

    typedef logic [KEY_BITS-1:0] t_key;
    typedef logic [POS_W-1:0]    t_pos;
endpackage
`default_nettype wire

[hdl/isb_ram.sv]
// generic simple dual-port ram, one write and one registered read
// no dependencies
`default_nettype none
module isb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[hdl/interpolation_search_bound_core.sv]
// load beat: writes one table entry, no result
// search beat: empty range goes straight to the result, else probes till done;
// each probe takes three reads on the single table read port and a 13-step divider
// one item in flight at a time; the result register lets the next beat in
// synchronous active-low reset clears control state; table contents undefined until loaded
`default_nettype none
`include "interpolation_search_bound_core_macros.svh"
module interpolation_search_bound_core
    import isb_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // load_index, load_data, search_key, range_first, range_past, zero fill
    input  wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // kind
    input  wire logic                   i_s_axis_tuser,
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    // position, zero fill
    output logic      [OUT_TDATA_W-1:0] o_m_axis_tdata
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RDF   = 4'd1;
    localparam logic [3:0] S_RDL   = 4'd2;
    localparam logic [3:0] S_CHK   = 4'd3;
    localparam logic [3:0] S_MUL   = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_PROBE = 4'd6;
    localparam logic [3:0] S_CMP   = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    localparam t_pos DEPTH_POS = t_pos'(TABLE_DEPTH);

    logic [3:0]             r_state, n_state;
    t_pos                   r_lo, n_lo, r_hi, n_hi, r_res, n_res, r_probe, n_probe;
    t_key                   r_key, n_key, r_first, n_first, r_off, n_off;
    t_key                   r_span, n_span, r_rem, n_rem;
    t_pos                   r_width, n_width, r_sh, n_sh, r_quo, n_quo;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic                   r_out_valid, n_out_valid;
    t_pos                   r_out_pos, n_out_pos;

    logic                   in_acc;
    t_pos                   in_lo, in_hi, q_clamp;
    logic [KEY_BITS+POS_W-1:0] prod;
    logic [KEY_BITS:0]      div_trial;
    logic [IDX_W-1:0]       rd_addr;
    t_key                   rd_data;

    assign in_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_TDATA_W'(r_out_pos);

    isb_ram #(.WIDTH(KEY_BITS), .DEPTH(TABLE_DEPTH)) u_table (
        .i_clk   (i_clk),
        .i_we    (in_acc && i_s_axis_tuser == KIND_LOAD),
        .i_waddr (i_s_axis_tdata[IN_IDX_LO +: IDX_W]),
        .i_wdata (i_s_axis_tdata[IN_DATA_LO +: KEY_BITS]),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    always_comb begin
        in_lo = i_s_axis_tdata[IN_FIRST_LO +: POS_W];
        in_hi = i_s_axis_tdata[IN_PAST_LO +: POS_W];
        if (in_lo > DEPTH_POS) begin
            in_lo = DEPTH_POS;
        end
        if (in_hi > DEPTH_POS) begin
            in_hi = DEPTH_POS;
        end
        prod      = KEY_BITS'(r_off) * r_width;
        div_trial = {r_rem, r_sh[POS_W-1]};
        q_clamp   = (r_quo >= r_width) ? r_width - 1'b1 : r_quo;
    end

    always_comb begin
        n_state = r_state; n_lo = r_lo; n_hi = r_hi; n_res = r_res; n_probe = r_probe;
        n_key = r_key; n_first = r_first; n_off = r_off; n_span = r_span;
        n_rem = r_rem; n_width = r_width; n_sh = r_sh; n_quo = r_quo; n_cnt = r_cnt;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_pos = r_out_pos;
        rd_addr = r_lo[IDX_W-1:0];
        case (r_state)
            S_IDLE: begin
                if (in_acc && i_s_axis_tuser == KIND_SEARCH) begin
                    n_key = i_s_axis_tdata[IN_KEY_LO +: KEY_BITS];
                    n_lo  = in_lo;
                    n_hi  = in_hi;
                    n_res = in_lo;
                    n_state = (in_lo >= in_hi) ? S_DONE : S_RDF;
                end
            end
            S_RDF: begin
                rd_addr = r_lo[IDX_W-1:0];
                n_state = S_RDL;
            end
            S_RDL: begin
                n_first = rd_data;
                rd_addr = IDX_W'(r_hi - 1'b1);
                n_state = S_CHK;
            end
            S_CHK: begin
                // rd_data holds the last entry of the range
                n_off   = r_key - r_first;
                n_span  = rd_data - r_first;
                n_width = r_hi - r_lo;
                if (r_key <= r_first) begin
                    n_res = r_lo; n_state = S_DONE;
                end else if (r_key > rd_data) begin
                    n_res = r_hi; n_state = S_DONE;
                end else if (r_key == rd_data) begin
                    n_res = r_hi - 1'b1; n_state = S_DONE;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                // upper product bits are below span since width fits POS_W bits
                n_rem   = prod[KEY_BITS+POS_W-1:POS_W];
                n_sh    = prod[POS_W-1:0];
                n_quo   = '0;
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_sh = {r_sh[POS_W-2:0], 1'b0};
                if (div_trial >= {1'b0, r_span}) begin
                    n_rem = KEY_BITS'(div_trial - {1'b0, r_span});
                    n_quo = {r_quo[POS_W-2:0], 1'b1};
                end else begin
                    n_rem = div_trial[KEY_BITS-1:0];
                    n_quo = {r_quo[POS_W-2:0], 1'b0};
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(POS_W - 1)) begin
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                n_probe = r_lo + q_clamp;
                rd_addr = IDX_W'(r_lo + q_clamp);
                n_state = S_CMP;
            end
            S_CMP: begin
                if (rd_data == r_key) begin
                    n_res = r_probe; n_state = S_DONE;
                end else begin
                    if (rd_data > r_key) begin
                        n_hi = r_probe;
                    end else begin
                        n_lo = r_probe + 1'b1;
                    end
                    n_res = (rd_data > r_key) ? r_lo : r_probe + 1'b1;
                    n_state = ((rd_data > r_key) ? (r_lo < r_probe)
                                                 : (r_probe + 1'b1 < r_hi)) ? S_RDF : S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_pos   = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_lo <= n_lo; r_hi <= n_hi; r_res <= n_res; r_probe <= n_probe;
        r_key <= n_key; r_first <= n_first; r_off <= n_off; r_span <= n_span;
        r_rem <= n_rem; r_width <= n_width; r_sh <= n_sh; r_quo <= n_quo;
        r_cnt <= n_cnt; r_out_pos <= n_out_pos;
    end

    `ISB_ASSERT_IMPL(a_div_rem, r_state == S_DIV, r_rem < r_span, "divider remainder not below span")
    `ISB_ASSERT_IMPL(a_range_ok, r_state == S_RDF, r_lo < r_hi && r_hi <= DEPTH_POS, "bad search range")
    `ISB_ASSERT_IMPL(a_empty_done, in_acc && i_s_axis_tuser == KIND_SEARCH && in_lo >= in_hi, ##1 r_state == S_DONE, "empty range not finished at once")
endmodule
`default_nettype wire

[bench/isb_checker.sv]
// checker for the interpolation search bound core: watches both streams,
// keeps its own key table, predicts each search position and compares
// depends on isb_pkg
module isb_checker
    import isb_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_tvalid,
    input  wire logic                   i_s_tready,
    input  wire logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  wire logic                   i_s_tuser,
    input  wire logic                   i_m_tvalid,
    input  wire logic                   i_m_tready,
    input  wire logic [OUT_TDATA_W-1:0] i_m_tdata,
    output int                          o_fail_count,
    output int                          o_pending
);
    logic [KEY_BITS-1:0] shadow_keys [TABLE_DEPTH];
    t_pos                expected_positions[$];

    assign o_pending = expected_positions.size();

    function automatic logic [KEY_BITS-1:0] entry_at(logic [POS_W:0] idx);
        if (idx >= TABLE_DEPTH) begin
            return '0;
        end
        return shadow_keys[idx[IDX_W-1:0]];
    endfunction

    function automatic t_pos locate_key(logic [KEY_BITS-1:0] key,
                                        logic [POS_W:0] lo_in, logic [POS_W:0] hi_in);
        logic [POS_W:0]      lo, hi, p;
        logic [KEY_BITS-1:0] head, tail, v, width;
        logic [127:0]        prod;
        logic [127:0]        q;
        lo = lo_in;
        hi = hi_in;
        while (lo < hi) begin
            head = entry_at(lo);
            tail = entry_at(hi - 1);
            if (key <= head) return t_pos'(lo);
            if (key > tail) return t_pos'(hi);
            if (key == tail) return t_pos'(hi - 1);
            width = 64'(hi - lo);
            prod  = 128'(key - head) * 128'(width);
            q     = prod / 128'(tail - head);
            if (q >= 128'(width)) q = 128'(width) - 1;
            p = lo + (POS_W+1)'(q);
            v = entry_at(p);
            if (v > key) hi = p;
            else if (v < key) lo = p + 1;
            else return t_pos'(p);
        end
        return t_pos'(lo);
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        o_fail_count++;
    endtask

    initial o_fail_count = 0;

    always @(posedge i_clk) begin
        logic [POS_W:0] lo, hi;
        t_pos           want;
        if (i_rst_n && i_s_tvalid && i_s_tready) begin
            if (i_s_tuser == KIND_LOAD) begin
                shadow_keys[i_s_tdata[IN_IDX_LO +: IDX_W]] = i_s_tdata[IN_DATA_LO +: KEY_BITS];
            end else begin
                lo = (POS_W+1)'(i_s_tdata[IN_FIRST_LO +: 13]);
                hi = (POS_W+1)'(i_s_tdata[IN_PAST_LO +: 13]);
                if (lo > TABLE_DEPTH) lo = TABLE_DEPTH;
                if (hi > TABLE_DEPTH) hi = TABLE_DEPTH;
                want = (lo >= hi) ? t_pos'(lo)
                                  : locate_key(i_s_tdata[IN_KEY_LO +: KEY_BITS], lo, hi);
                expected_positions.push_back(want);
            end
        end
        if (i_rst_n && i_m_tvalid && i_m_tready) begin
            if (expected_positions.size() == 0) begin
                report_mismatch($sformatf("unexpected position %0d", i_m_tdata[12:0]));
            end else begin
                want = expected_positions.pop_front();
                if (i_m_tdata[12:0] !== want) begin
                    report_mismatch($sformatf("position %0d, want %0d",
                                              i_m_tdata[12:0], want));
                end
            end
        end
    end
endmodule

[bench/tb_top.sv]
// top of the interpolation search bound testbench: drives load and search
// beats with random gaps and stalls; depends on isb_pkg, isb_checker and the core
module tb_top;
    import isb_pkg::*;

    localparam int WATCHDOG_LIMIT = 100000;
    localparam int FILL_COUNT     = 400;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;   // load_index, load_data, search_key, first, past
    logic                   s_tuser;   // kind
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;   // position
    int                     fail_count;
    int                     pending;
    int                     idle_pct;
    int                     stall_pct;
    int                     quiet_cycles;
    int                     filled;   // entries 0..filled-1 loaded

    interpolation_search_bound_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata), .i_s_axis_tuser(s_tuser),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(m_tdata)
    );

    isb_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_s_tuser(s_tuser), .i_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .i_m_tdata(m_tdata), .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles > WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_beat(input logic kind, input logic [11:0] idx, input logic [63:0] data,
                             input logic [63:0] key, input logic [12:0] first,
                             input logic [12:0] past);
        logic [IN_TDATA_W-1:0] beat;
        beat = '0;
        beat[IN_IDX_LO +: 12]   = idx;
        beat[IN_DATA_LO +: 64]  = data;
        beat[IN_KEY_LO +: 64]   = key;
        beat[IN_FIRST_LO +: 13] = first;
        beat[IN_PAST_LO +: 13]  = past;
        if ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < idle_pct) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= beat;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    // sorted fill of entries [0, n) with a random step profile
    task automatic load_sorted(input int n, input int step_bits);
        logic [63:0] v;
        v = $urandom_range(3);
        for (int i = 0; i < n; i++) begin
            send_beat(KIND_LOAD, 12'(i), v, 64'($urandom), 13'($urandom), 13'($urandom));
            if ($urandom_range(5) != 0) begin
                v = v + (({$urandom, $urandom} >> (64 - step_bits)) | 64'd1);
            end
        end
        if (n > filled) filled = n;
    endtask

    function automatic logic [63:0] pick_key();
        logic [63:0] k;
        case ($urandom_range(3))
            0: k = {$urandom, $urandom};
            default: k = u_checker.shadow_keys[$urandom_range(filled - 1)]
                         + 64'($signed($urandom_range(2)) - 1);
        endcase
        return k;
    endfunction

    task automatic random_search();
        int a, b;
        if ($urandom_range(19) == 0) begin
            // wild bounds over 13 bits; a nonempty range must stay inside the loaded part
            a = $urandom_range(8191);
            b = a;
            if ($urandom_range(1)) b = $urandom_range(8191);
            if (a < b && a < TABLE_DEPTH && b > filled) b = a;
        end else begin
            a = $urandom_range(filled - 1);
            b = $urandom_range(filled);
            if (b < a) begin
                int t;
                t = a; a = b; b = t;
            end
        end
        send_beat(KIND_SEARCH, 12'($urandom), {$urandom, $urandom}, pick_key(),
                  13'(a), 13'(b));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = KIND_LOAD;
        m_tready = 1'b1;
        idle_pct = 0;
        stall_pct = 0;
        quiet_cycles = 0;
        filled = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: sorted fill, extremes at both ends, last table entry alone
        load_sorted(FILL_COUNT, 50);
        send_beat(KIND_LOAD, 12'd0, 64'd0, '0, '0, '0);
        send_beat(KIND_LOAD, 12'(FILL_COUNT - 1), 64'hFFFF_FFFF_FFFF_FFFF, '0, '0, '0);
        send_beat(KIND_LOAD, 12'hFFF, 64'd1000, '0, '0, '0);
        send_beat(KIND_SEARCH, '0, '0, 64'd0, 13'd0, 13'(FILL_COUNT));      // at or below first
        send_beat(KIND_SEARCH, '0, '0, 64'hFFFF_FFFF_FFFF_FFFF, 13'd0,
                  13'(FILL_COUNT));                                         // equals last
        send_beat(KIND_SEARCH, '0, '0, 64'hFFFF_FFFF_FFFF_FFFE, 13'd0,
                  13'(FILL_COUNT - 1));                                     // above last
        send_beat(KIND_SEARCH, '0, '0, 64'd5, 13'd8191, 13'd8191);        // saturated bounds
        send_beat(KIND_SEARCH, '0, '0, 64'd5, 13'd4096, 13'd8191);
        send_beat(KIND_SEARCH, '0, '0, 64'd5, 13'd100, 13'd50);           // inverted range
        send_beat(KIND_SEARCH, '0, '0, 64'd5, 13'd7, 13'd7);              // empty range
        send_beat(KIND_SEARCH, '0, '0, u_checker.shadow_keys[200], 13'd0, 13'(FILL_COUNT));
        send_beat(KIND_SEARCH, '0, '0, u_checker.shadow_keys[200] + 1, 13'd0,
                  13'(FILL_COUNT));
        send_beat(KIND_SEARCH, '0, '0, 64'h8000_0000_0000_0000, 13'd1, 13'(FILL_COUNT - 1));
        send_beat(KIND_SEARCH, '0, '0, 64'd1000, 13'd4095, 13'd4096);     // last table entry
        send_beat(KIND_SEARCH, '0, '0, 64'd5, 13'd4095, 13'd8191);
        send_beat(KIND_SEARCH, '0, '0, 64'd2000, 13'd4095, 13'd4096);
        drain();

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 82; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 82; end
                3: begin idle_pct = 20; stall_pct = 20; end
                default: begin idle_pct = 0; stall_pct = 0; end
            endcase
            // small rewrite with duplicates or a wider step, sometimes unsorted
            load_sorted($urandom_range(2, 40), (phase % 2) ? 4 : 63);
            if (phase == 4) begin
                for (int i = 0; i < 20; i++) begin
                    send_beat(KIND_LOAD, 12'($urandom_range(39)), {$urandom, $urandom},
                              '0, '0, '0);
                end
            end
            for (int i = 0; i < 200; i++) begin
                if ($urandom_range(9) == 0) begin
                    send_beat(KIND_LOAD, 12'($urandom_range(filled - 1)),
                              u_checker.shadow_keys[$urandom_range(filled - 1)], '0, '0, '0);
                end else begin
                    random_search();
                end
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
